FILE: hdl/pilp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pilp_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int PHASE_WIDTH    = 16;
  localparam int ADDR_WIDTH     = 5;

  // register indexes on the apb port (byte address is 4 * index)
  localparam logic [2:0] REG_SETPOINT         = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN        = 3'd1;
  localparam logic [2:0] REG_INTEGRAL_GAIN    = 3'd2;
  localparam logic [2:0] REG_STEP_RATIO       = 3'd3;
  localparam logic [2:0] REG_TICKS_PER_SAMPLE = 3'd4;
  localparam logic [2:0] REG_INITIAL_OUTPUT   = 3'd5;
  localparam logic [2:0] REG_INITIAL_DRIVE    = 3'd6;
  localparam logic [2:0] REG_INITIAL_INTEGRAL = 3'd7;

  localparam logic [31:0] RST_SETPOINT         = 32'd1310720;
  localparam logic [31:0] RST_PROP_GAIN        = 32'd196608;
  localparam logic [31:0] RST_INTEGRAL_GAIN    = 32'd26214;
  localparam logic [15:0] RST_STEP_RATIO       = 16'd6554;
  localparam logic [15:0] RST_TICKS_PER_SAMPLE = 16'd10;
  localparam logic [31:0] RST_INITIAL_OUTPUT   = 32'd0;
  localparam logic [31:0] RST_INITIAL_DRIVE    = 32'd0;
  localparam logic [31:0] RST_INITIAL_INTEGRAL = 32'd0;

  // coefficient select for the shared multiplier
  localparam logic [1:0] MUL_KI   = 2'd0;
  localparam logic [1:0] MUL_KP   = 2'd1;
  localparam logic [1:0] MUL_STEP = 2'd2;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] prop_gain;
    logic signed [31:0] integral_gain;
    logic [15:0]        step_ratio;
    logic [15:0]        ticks_per_sample;
    logic signed [31:0] initial_output;
    logic signed [31:0] initial_drive;
    logic signed [31:0] initial_integral;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       calc_err;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       add_int;
    logic       add_drv;
    logic       dbl;
    logic       diff;
    logic       add_plant;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic phase_zero;
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/pilp_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// q16.16 multiply, sign-magnitude, 32 bits of b per cycle,
// then round half away from zero and saturate
module pilp_mul #(
  parameter int DATA_WIDTH = pilp_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [32:0]           a,
  input  wire logic signed [DATA_WIDTH-1:0] b,
  output logic                              done,
  output logic signed [DATA_WIDTH-1:0]      res
);

  localparam int NCH = (DATA_WIDTH + 31) / 32;
  localparam int UW  = 32 * NCH;
  localparam int PW  = UW + 32;
  localparam int MW  = PW - 15;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                  busy;
  logic                  fin;
  logic [CW-1:0]         cnt;
  logic                  neg;
  logic [31:0]           ua;
  logic [UW-1:0]         ubs;
  logic [PW-1:0]         acc;

  logic [32:0]           a_abs;
  logic [DATA_WIDTH-1:0] b_abs;
  logic [63:0]           prod;
  logic [PW:0]           rnd;
  logic [MW-1:0]         mag;
  logic                  ovf;
  logic [DATA_WIDTH-1:0] lo;
  logic [DATA_WIDTH-1:0] res_next;

  assign a_abs = a[32] ? 33'(-a) : 33'(a);
  assign b_abs = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
  assign prod  = ua * ubs[UW-1 -: 32];

  assign rnd = {1'b0, acc} + (PW+1)'(32'h0000_8000);
  assign mag = rnd[PW:16];
  assign ovf = |mag[MW-1:DATA_WIDTH-1];
  assign lo  = mag[DATA_WIDTH-1:0];

  always_comb begin
    if (ovf) begin
      res_next = neg ? VMIN : VMAX;
    end else begin
      res_next = neg ? DATA_WIDTH'(-lo) : lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= CW'(NCH - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= a_abs[31:0];
      ubs <= UW'(b_abs);
      neg <= a[32] ^ b[DATA_WIDTH-1];
      acc <= '0;
    end else if (busy) begin
      // most significant chunk first
      acc <= (acc << 32) + PW'(prod);
      ubs <= ubs << 32;
    end else if (fin) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pilp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pilp_dp #(
  parameter int DATA_WIDTH = pilp_pkg::DATA_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pilp_pkg::cfg_t cfg,
  input  wire pilp_pkg::cmd_t cmd,
  output pilp_pkg::sts_t     sts,
  input  wire logic          start_run,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic signed [31:0] plant_output,
  output logic signed [31:0] drive
);

  localparam int DW = DATA_WIDTH;
  localparam int EW = ((DW > 32) ? DW : 32) + 2;
  localparam int PH = pilp_pkg::PHASE_WIDTH;

  localparam logic signed [EW-1:0] W_MAX = $signed({{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [EW-1:0] W_MIN = ~W_MAX;
  localparam logic signed [EW-1:0] O_MAX = $signed({{(EW-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [EW-1:0] O_MIN = ~O_MAX;

  function automatic logic signed [EW-1:0] ext_w(input logic signed [DW-1:0] v);
    ext_w = $signed({{(EW-DW){v[DW-1]}}, v});
  endfunction

  function automatic logic signed [EW-1:0] ext_32(input logic signed [31:0] v);
    ext_32 = $signed({{(EW-32){v[31]}}, v});
  endfunction

  function automatic logic signed [DW-1:0] sat_w(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = (v > W_MAX) ? W_MAX : ((v < W_MIN) ? W_MIN : v);
    sat_w = c[DW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [DW-1:0] v);
    logic signed [EW-1:0] x;
    logic signed [EW-1:0] c;
    x = ext_w(v);
    c = (x > O_MAX) ? O_MAX : ((x < O_MIN) ? O_MIN : x);
    sat_32 = c[31:0];
  endfunction

  logic signed [DW-1:0] plant;
  logic signed [DW-1:0] drv;
  logic signed [DW-1:0] integ;
  logic [PH-1:0]        phase;
  logic signed [DW-1:0] work;

  logic signed [32:0]   mul_a;
  logic                 mul_done;
  logic signed [DW-1:0] mres;

  logic [PH-1:0]        period;
  logic [PH:0]          phase_inc;

  always_comb begin
    case (cmd.mul_sel)
      pilp_pkg::MUL_KI:   mul_a = {cfg.integral_gain[31], cfg.integral_gain};
      pilp_pkg::MUL_KP:   mul_a = {cfg.prop_gain[31], cfg.prop_gain};
      pilp_pkg::MUL_STEP: mul_a = $signed({17'd0, cfg.step_ratio});
      default:            mul_a = '0;
    endcase
  end

  pilp_mul #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mul_start),
    .a    (mul_a),
    .b    (work),
    .done (mul_done),
    .res  (mres)
  );

  // a period of zero ticks behaves as one
  assign period    = (cfg.ticks_per_sample == '0) ? PH'(1) : cfg.ticks_per_sample;
  assign phase_inc = {1'b0, phase} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plant <= '0;
      drv   <= '0;
      integ <= '0;
      phase <= '0;
    end else begin
      if (cmd.accept && start_run) begin
        plant <= sat_w(ext_32(cfg.initial_output));
        drv   <= sat_w(ext_32(cfg.initial_drive));
        integ <= sat_w(ext_32(cfg.initial_integral));
        phase <= '0;
      end
      if (cmd.add_int) begin
        integ <= sat_w(ext_w(integ) + ext_w(mres));
      end
      if (cmd.add_drv) begin
        drv <= sat_w(ext_w(mres) + ext_w(integ));
      end
      if (cmd.add_plant) begin
        plant <= sat_w(ext_w(plant) + ext_w(mres));
        // a shortened period wraps at once
        phase <= (phase_inc >= {1'b0, period}) ? '0 : phase_inc[PH-1:0];
      end
    end
  end

  // scratch operand for the multiplier: error, then 2u, then 2u - y
  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      work <= sat_w(ext_32(cfg.setpoint) - ext_w(plant));
    end else if (cmd.dbl) begin
      work <= sat_w(ext_w(drv) + ext_w(drv));
    end else if (cmd.diff) begin
      work <= sat_w(ext_w(work) - ext_w(plant));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      plant_output <= sat_32(plant);
      drive        <= sat_32(drv);
    end
  end

  assign sts.phase_zero = (phase == '0);
  assign sts.mul_done   = mul_done;
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

FILE: hdl/pilp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pilp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire pilp_pkg::sts_t sts,
  output pilp_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_KI_GO   = 4'd2;
  localparam logic [3:0] S_KI_WAIT = 4'd3;
  localparam logic [3:0] S_KP_GO   = 4'd4;
  localparam logic [3:0] S_KP_WAIT = 4'd5;
  localparam logic [3:0] S_DBL     = 4'd6;
  localparam logic [3:0] S_DIFF    = 4'd7;
  localparam logic [3:0] S_ST_GO   = 4'd8;
  localparam logic [3:0] S_ST_WAIT = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // controller update only on the first tick of a period
        if (sts.phase_zero) begin
          cmd.calc_err = 1'b1;
          state_next   = S_KI_GO;
        end else begin
          state_next = S_DBL;
        end
      end
      S_KI_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = pilp_pkg::MUL_KI;
        state_next    = S_KI_WAIT;
      end
      S_KI_WAIT: begin
        if (sts.mul_done) begin
          cmd.add_int = 1'b1;
          state_next  = S_KP_GO;
        end
      end
      S_KP_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = pilp_pkg::MUL_KP;
        state_next    = S_KP_WAIT;
      end
      S_KP_WAIT: begin
        if (sts.mul_done) begin
          cmd.add_drv = 1'b1;
          state_next  = S_DBL;
        end
      end
      S_DBL: begin
        cmd.dbl    = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_ST_GO;
      end
      S_ST_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = pilp_pkg::MUL_STEP;
        state_next    = S_ST_WAIT;
      end
      S_ST_WAIT: begin
        if (sts.mul_done) begin
          cmd.add_plant = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pi_loop_with_first_order_plant_core.sv
`timescale 1ns / 1ps
`default_nettype none

// a tick runs the controller update and the plant update on the first tick of a controller
// period and only the plant update on the other ticks; one tick is in flight at a time, so
// the block takes no new input beat before the current tick's result beat is emitted.
// the work is done by the single shared multiplier (N = ceil(DATA_WIDTH/32) slices of 32 bits,
// one 32-bit slice per cycle, then rounding), used two times for the controller update and once for the plant.
// synchronous reset loads register defaults and clears plant, drive, integral and phase.
module pi_loop_with_first_order_plant_core #(
  parameter int DATA_WIDTH = pilp_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              start_run,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [31:0]                     plant_output,
  output logic signed [31:0]                     drive,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pilp_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  pilp_pkg::cfg_t cfg;
  pilp_pkg::cmd_t cmd;
  pilp_pkg::sts_t sts;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint         <= pilp_pkg::RST_SETPOINT;
      cfg.prop_gain        <= pilp_pkg::RST_PROP_GAIN;
      cfg.integral_gain    <= pilp_pkg::RST_INTEGRAL_GAIN;
      cfg.step_ratio       <= pilp_pkg::RST_STEP_RATIO;
      cfg.ticks_per_sample <= pilp_pkg::RST_TICKS_PER_SAMPLE;
      cfg.initial_output   <= pilp_pkg::RST_INITIAL_OUTPUT;
      cfg.initial_drive    <= pilp_pkg::RST_INITIAL_DRIVE;
      cfg.initial_integral <= pilp_pkg::RST_INITIAL_INTEGRAL;
    end else if (wr_en) begin
      case (reg_idx)
        pilp_pkg::REG_SETPOINT:         cfg.setpoint         <= pwdata;
        pilp_pkg::REG_PROP_GAIN:        cfg.prop_gain        <= pwdata;
        pilp_pkg::REG_INTEGRAL_GAIN:    cfg.integral_gain    <= pwdata;
        pilp_pkg::REG_STEP_RATIO:       cfg.step_ratio       <= pwdata[15:0];
        pilp_pkg::REG_TICKS_PER_SAMPLE: cfg.ticks_per_sample <= pwdata[15:0];
        pilp_pkg::REG_INITIAL_OUTPUT:   cfg.initial_output   <= pwdata;
        pilp_pkg::REG_INITIAL_DRIVE:    cfg.initial_drive    <= pwdata;
        pilp_pkg::REG_INITIAL_INTEGRAL: cfg.initial_integral <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pilp_pkg::REG_SETPOINT:         prdata = cfg.setpoint;
      pilp_pkg::REG_PROP_GAIN:        prdata = cfg.prop_gain;
      pilp_pkg::REG_INTEGRAL_GAIN:    prdata = cfg.integral_gain;
      pilp_pkg::REG_STEP_RATIO:       prdata = {16'd0, cfg.step_ratio};
      pilp_pkg::REG_TICKS_PER_SAMPLE: prdata = {16'd0, cfg.ticks_per_sample};
      pilp_pkg::REG_INITIAL_OUTPUT:   prdata = cfg.initial_output;
      pilp_pkg::REG_INITIAL_DRIVE:    prdata = cfg.initial_drive;
      pilp_pkg::REG_INITIAL_INTEGRAL: prdata = cfg.initial_integral;
      default:                        prdata = '0;
    endcase
  end

  pilp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  pilp_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .start_run   (start_run),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .plant_output(plant_output),
    .drive       (drive)
  );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic signed [31:0] plant_output;
    logic signed [31:0] drive;
  } loop_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic start_run = 1'b0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pilp_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire in_stall;
  wire out_valid;
  wire signed [31:0] plant_output;
  wire signed [31:0] drive;
  wire [31:0] prdata;
  wire pready;

  pi_loop_with_first_order_plant_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .start_run(start_run),
    .out_valid(out_valid), .out_stall(out_stall),
    .plant_output(plant_output), .drive(drive),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of registers and loop state
  logic [31:0] loop_regs [8];
  longint plant_value = 0;
  longint drive_value = 0;
  longint integral_sum = 0;
  int unsigned tick_phase = 0;

  logic pending_starts [$];
  loop_sample_t expected_samples [$];
  logic tick_taken = 1'b0;
  bit idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int ticks_checked = 0;
  int settings_used = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // q16.16 product, round half away from zero, then clamp
  function automatic longint mul_q16(input longint a, input longint b);
    logic neg;
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned mag;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    mag = (ua * ub + 64'h8000) >> 16;
    if (neg) return (mag >= 64'h8000_0000) ? Q_MIN : -longint'(mag);
    return (mag > 64'h7fff_ffff) ? Q_MAX : longint'(mag);
  endfunction

  function automatic longint reg_q(input logic [2:0] idx);
    return longint'($signed(loop_regs[idx]));
  endfunction

  function automatic loop_sample_t advance_loop(input logic start);
    loop_sample_t s;
    int unsigned period;
    longint err;
    longint diff;
    longint step;
    int unsigned nxt;
    period = loop_regs[pilp_pkg::REG_TICKS_PER_SAMPLE][15:0];
    if (period == 0) period = 1;
    step = longint'(loop_regs[pilp_pkg::REG_STEP_RATIO][15:0]);
    if (start) begin
      plant_value = reg_q(pilp_pkg::REG_INITIAL_OUTPUT);
      drive_value = reg_q(pilp_pkg::REG_INITIAL_DRIVE);
      integral_sum = reg_q(pilp_pkg::REG_INITIAL_INTEGRAL);
      tick_phase = 0;
    end
    if (tick_phase == 0) begin
      err = sat_q(reg_q(pilp_pkg::REG_SETPOINT) - plant_value);
      integral_sum = sat_q(integral_sum +
                           mul_q16(reg_q(pilp_pkg::REG_INTEGRAL_GAIN), err));
      drive_value = sat_q(mul_q16(reg_q(pilp_pkg::REG_PROP_GAIN), err) + integral_sum);
    end
    diff = sat_q(sat_q(drive_value + drive_value) - plant_value);
    plant_value = sat_q(plant_value + mul_q16(step, diff));
    nxt = tick_phase + 1;
    tick_phase = (nxt >= period) ? 0 : (nxt & 16'hffff);
    s.plant_output = plant_value[31:0];
    s.drive = drive_value[31:0];
    return s;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 7) return 32'h7fff_ffff;
    if (r < 13) return 32'h8000_0000;
    if (r < 17) return 32'h0;
    if (r < 32) return $urandom();
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == pilp_pkg::REG_STEP_RATIO || idx == pilp_pkg::REG_TICKS_PER_SAMPLE)
      loop_regs[idx] = val & 32'h0000_ffff;
    else
      loop_regs[idx] = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until the block has nothing in flight
  task automatic drain_loop();
    while (pending_starts.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_ticks(input int n, input logic with_start);
    for (int i = 0; i < n; i++) pending_starts.push_back(with_start && i == 0);
  endtask

  task automatic random_settings();
    int unsigned r;
    logic [15:0] ticks;
    write_reg(pilp_pkg::REG_SETPOINT, pick_word(100 << 16));
    write_reg(pilp_pkg::REG_PROP_GAIN, pick_word(4 << 16));
    write_reg(pilp_pkg::REG_INTEGRAL_GAIN, pick_word(1 << 16));
    write_reg(pilp_pkg::REG_STEP_RATIO, $urandom());
    r = $urandom_range(0, 99);
    if (r < 8) ticks = 16'd0;
    else if (r < 12) ticks = 16'hffff;
    else if (r < 22) ticks = $urandom_range(13, 65535);
    else ticks = $urandom_range(1, 12);
    write_reg(pilp_pkg::REG_TICKS_PER_SAMPLE, {16'($urandom()), ticks});
    write_reg(pilp_pkg::REG_INITIAL_OUTPUT, pick_word(50 << 16));
    write_reg(pilp_pkg::REG_INITIAL_DRIVE, pick_word(50 << 16));
    write_reg(pilp_pkg::REG_INITIAL_INTEGRAL, pick_word(50 << 16));
    settings_used++;
  endtask

  task automatic random_chunk(input int n_items);
    int count;
    int len;
    int unsigned r;
    count = 0;
    while (count < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len = $urandom_range(3, 25);
        push_ticks(len, 1'b1);
      end else if (r < 9) begin
        len = $urandom_range(1, 8);
        push_ticks(len, 1'b0);
      end else begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) pending_starts.push_back(1'b1);
      end
      count += len;
    end
  endtask

  // sender: next beat goes out once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_starts.size() != 0) begin
        in_valid <= 1'b1;
        start_run <= pending_starts.pop_front();
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    loop_sample_t want;
    if (rst) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("result beat with no tick pending: plant_output %0d drive %0d",
                 plant_output, drive);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          ticks_checked++;
          if (plant_output !== want.plant_output) begin
            $error("plant_output: expected %0d, got %0d", want.plant_output, plant_output);
            fail_count++;
          end
          if (drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, drive);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_samples.push_back(advance_loop(start_run));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, expected_samples.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    loop_regs[pilp_pkg::REG_SETPOINT] = pilp_pkg::RST_SETPOINT;
    loop_regs[pilp_pkg::REG_PROP_GAIN] = pilp_pkg::RST_PROP_GAIN;
    loop_regs[pilp_pkg::REG_INTEGRAL_GAIN] = pilp_pkg::RST_INTEGRAL_GAIN;
    loop_regs[pilp_pkg::REG_STEP_RATIO] = {16'h0, pilp_pkg::RST_STEP_RATIO};
    loop_regs[pilp_pkg::REG_TICKS_PER_SAMPLE] = {16'h0, pilp_pkg::RST_TICKS_PER_SAMPLE};
    loop_regs[pilp_pkg::REG_INITIAL_OUTPUT] = pilp_pkg::RST_INITIAL_OUTPUT;
    loop_regs[pilp_pkg::REG_INITIAL_DRIVE] = pilp_pkg::RST_INITIAL_DRIVE;
    loop_regs[pilp_pkg::REG_INITIAL_INTEGRAL] = pilp_pkg::RST_INITIAL_INTEGRAL;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: one tick from the reset state, then a full period and a wrap
    settings_used = 1;
    pending_starts.push_back(1'b0);
    push_ticks(11, 1'b1);
    drain_loop();

    // saturation corners, zero period means refresh on every tick
    write_reg(pilp_pkg::REG_SETPOINT, 32'h7fff_ffff);
    write_reg(pilp_pkg::REG_PROP_GAIN, 32'h7fff_ffff);
    write_reg(pilp_pkg::REG_INTEGRAL_GAIN, 32'h8000_0000);
    write_reg(pilp_pkg::REG_STEP_RATIO, 32'hffff_ffff);
    write_reg(pilp_pkg::REG_TICKS_PER_SAMPLE, 32'hffff_0000);
    write_reg(pilp_pkg::REG_INITIAL_OUTPUT, 32'h8000_0000);
    write_reg(pilp_pkg::REG_INITIAL_DRIVE, 32'h7fff_ffff);
    write_reg(pilp_pkg::REG_INITIAL_INTEGRAL, 32'h8000_0000);
    settings_used++;
    push_ticks(4, 1'b1);
    drain_loop();
    write_reg(pilp_pkg::REG_SETPOINT, 32'h8000_0000);
    write_reg(pilp_pkg::REG_PROP_GAIN, 32'h8000_0000);
    push_ticks(2, 1'b0);
    drain_loop();

    // period shortened below the current phase mid-run
    write_reg(pilp_pkg::REG_SETPOINT, 32'd10 << 16);
    write_reg(pilp_pkg::REG_PROP_GAIN, 32'd2 << 16);
    write_reg(pilp_pkg::REG_INTEGRAL_GAIN, 32'd1 << 14);
    write_reg(pilp_pkg::REG_STEP_RATIO, 32'd8000);
    write_reg(pilp_pkg::REG_TICKS_PER_SAMPLE, 32'd8);
    write_reg(pilp_pkg::REG_INITIAL_OUTPUT, 32'h0);
    write_reg(pilp_pkg::REG_INITIAL_DRIVE, 32'h0);
    write_reg(pilp_pkg::REG_INITIAL_INTEGRAL, 32'h0);
    settings_used++;
    push_ticks(5, 1'b1);
    drain_loop();
    write_reg(pilp_pkg::REG_TICKS_PER_SAMPLE, 32'd3);
    push_ticks(2, 1'b0);
    drain_loop();

    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 4 != 1);
      random_settings();
      random_chunk(32);
      // sender holds off here until the block is empty
      if (ph == 3) drain_loop();
      random_chunk(32);
      drain_loop();
    end

    $display("checked %0d ticks over %0d register settings, start pulses and saturation",
             ticks_checked, settings_used);
    $display("%0d mismatches found", fail_count);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
